// ===== rtl/chbp_pkg.sv =====
`default_nettype none
package chbp_pkg;

	typedef enum logic [3:0] {
		PH_HEADERS = 4'b0001,
		PH_SIZE    = 4'b0010,
		PH_CONTENT = 4'b0100,
		PH_DONE    = 4'b1000
	} chbp_phase_t;

	localparam logic [7:0] LF_BYTE = 8'd10;
	localparam logic [7:0] CR_BYTE = 8'd13;
	localparam int unsigned HEX_DIGIT_BITS = 4;

	typedef struct packed {
		logic [7:0] content_byte;
		logic       last_content;
		logic       message_end;
	} chbp_result_t;

	function automatic logic [HEX_DIGIT_BITS-1:0] hex_value(input logic [7:0] b);
		logic [7:0] v;
		v = 8'd0;
		if (b inside {[8'h30:8'h39]}) begin
			v = b - 8'h30;
		end else if (b inside {[8'h61:8'h66]}) begin
			v = b - 8'h57;
		end else if (b inside {[8'h41:8'h46]}) begin
			v = b - 8'h37;
		end
		return v[HEX_DIGIT_BITS-1:0];
	endfunction

endpackage
`default_nettype wire

// ===== rtl/chbp_fsm.sv =====
`default_nettype none
module chbp_fsm #(
	parameter int LENGTH_BITS = 32
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  step,
	input  wire logic [7:0]            data_byte,
	output logic                       res_valid,
	output chbp_pkg::chbp_result_t     res
);

	localparam int DB = chbp_pkg::HEX_DIGIT_BITS;

	chbp_pkg::chbp_phase_t  phase_q, phase_d;
	logic                   line_empty_q, line_empty_d;
	logic [LENGTH_BITS-1:0] body_len_q, body_len_d;
	logic [LENGTH_BITS-1:0] passed_q, passed_d;
	logic [LENGTH_BITS-1:0] passed_inc;
	logic [DB-1:0]          digit;

	assign passed_inc = passed_q + {{(LENGTH_BITS-1){1'b0}}, 1'b1};
	assign digit      = chbp_pkg::hex_value(data_byte);

	always_comb begin
		phase_d      = phase_q;
		line_empty_d = line_empty_q;
		body_len_d   = body_len_q;
		passed_d     = passed_q;
		res_valid    = 1'b0;
		res          = '0;
		case (phase_q)
			chbp_pkg::PH_HEADERS: begin
				if (data_byte == chbp_pkg::LF_BYTE) begin
					if (line_empty_q) begin
						phase_d    = chbp_pkg::PH_SIZE;
						body_len_d = '0;
					end
					line_empty_d = 1'b1;
				end else if (data_byte != chbp_pkg::CR_BYTE) begin
					line_empty_d = 1'b0;
				end
			end
			chbp_pkg::PH_SIZE: begin
				if (data_byte == chbp_pkg::LF_BYTE) begin
					phase_d      = chbp_pkg::PH_CONTENT;
					passed_d     = '0;
					line_empty_d = 1'b1;
				end else if (data_byte != chbp_pkg::CR_BYTE) begin
					if (|body_len_q[LENGTH_BITS-1:LENGTH_BITS-DB]) begin
						body_len_d = '1;
					end else begin
						body_len_d = {body_len_q[LENGTH_BITS-DB-1:0], digit};
					end
				end
			end
			chbp_pkg::PH_CONTENT: begin
				res_valid = 1'b1;
				if (passed_q < body_len_q) begin
					passed_d         = passed_inc;
					res.content_byte = data_byte;
					res.last_content = (passed_inc == body_len_q);
				end else begin
					phase_d         = chbp_pkg::PH_DONE;
					res.message_end = 1'b1;
				end
			end
			chbp_pkg::PH_DONE: begin
			end
			default: begin
				phase_d = chbp_pkg::PH_DONE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= chbp_pkg::PH_HEADERS;
			line_empty_q <= 1'b1;
			body_len_q   <= '0;
			passed_q     <= '0;
		end else if (step) begin
			phase_q      <= phase_d;
			line_empty_q <= line_empty_d;
			body_len_q   <= body_len_d;
			passed_q     <= passed_d;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/chbp_out_buf.sv =====
`default_nettype none
module chbp_out_buf (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   push,
	input  wire chbp_pkg::chbp_result_t push_data,
	output logic                        full,
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output chbp_pkg::chbp_result_t      out_data
);

	chbp_pkg::chbp_result_t mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       pop;

	assign full      = count_q[1];
	assign out_valid = (count_q != 2'd0);
	assign pop       = out_valid && out_ready;
	assign out_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== rtl/http_chunked_body_parser_top.sv =====
// HTTP chunked body parser.
// Input channel: in_valid / in_ready with data_byte, one response byte per word.
// Output channel: out_valid / out_ready with content_byte, last_content and
// message_end. Header and size-line bytes produce no output word; each body
// byte produces one word, the final one flagged by last_content; the byte
// after the body produces one word with message_end set; later bytes are
// dropped.
// A word accepted at the input is registered in the input register, decoded
// against the parser state once the output buffer is not full, and written
// into the two-entry output buffer, which offers its result to the receiver.
// Throughput: one word per cycle while the output buffer is not full.
// When the receiver stalls, the output buffer fills; in_ready then drops
// once the input register holds a word and the buffer is full, and rises
// again in the cycle after the receiver takes a word.
// Reset (arst_n low, asynchronous) returns the parser to the header phase
// and empties the input register and output buffer.
`default_nettype none
module http_chunked_body_parser_top #(
	parameter int LENGTH_BITS = 32
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] data_byte,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [7:0]      content_byte,
	output logic            last_content,
	output logic            message_end
);

	logic                   valid_s1;
	logic [7:0]             data_s1;
	logic                   buf_full;
	logic                   step;
	logic                   res_valid;
	chbp_pkg::chbp_result_t res;
	chbp_pkg::chbp_result_t out_data;

	assign in_ready = !valid_s1 || !buf_full;
	assign step     = valid_s1 && !buf_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s1 <= data_byte;
		end
	end

	chbp_fsm #(
		.LENGTH_BITS(LENGTH_BITS)
	) u_fsm (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (step),
		.data_byte(data_s1),
		.res_valid(res_valid),
		.res      (res)
	);

	chbp_out_buf u_out_buf (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (step && res_valid),
		.push_data(res),
		.full     (buf_full),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	assign content_byte = out_data.content_byte;
	assign last_content = out_data.last_content;
	assign message_end  = out_data.message_end;

	a_end_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(message_end && last_content))
		else $error("message_end and last_content set together");

	a_end_zero_byte: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && message_end |-> content_byte == 8'd0)
		else $error("nonzero content_byte on message_end");

	a_hold_on_full: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && buf_full |=> valid_s1 && $stable(data_s1))
		else $error("input register lost a word while buffer full");

	a_full_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		buf_full |-> out_valid)
		else $error("buffer full without pending output");

endmodule
`default_nettype wire
